// ----- src/ringf_pkg.sv -----
// Shared types and constants for the ring FIFO with reverse and range filter.
package ringf_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int DATA_W       = 32;
  localparam int OPCODE_W     = 3;
  localparam int STATUS_W     = 2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH    = 3'd0,
    OP_POP     = 3'd1,
    OP_PEEK    = 3'd2,
    OP_REVERSE = 3'd3,
    OP_REMOVE  = 3'd4
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_REV_RA,
    S_REV_RB,
    S_REV_WA,
    S_REV_WB,
    S_RM_RD,
    S_RM_CHK
  } state_t;

endpackage

// ----- src/ring_fifo_with_reverse_and_range_filter_top.sv -----
// Top level: opcode sequencer around the entry store and shared index/compare unit.
//
// Items are accepted when start is high and busy is low; each item gives exactly one
// result, shown on status, read_data and fill_count for a single cycle with done high,
// and the receiver cannot stall it. Push, pop, peek and unused opcodes finish from
// the execute state, and the next item can be accepted in the result cycle.
// Reverse reads each front entry and its mirror, then writes each into the other's
// slot; remove-in-range reads and checks one entry at a time (finishing at once when
// the queue is empty). This is set by the single read port of the entry store and
// the one shared wrap-add/range-compare unit. Remove writes survivors into the other
// half of a double-size store and then swaps halves, so no copy-back pass is needed.
module ring_fifo_with_reverse_and_range_filter_top import ringf_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [OPCODE_W-1:0]      opcode,
  input  logic signed [DATA_W-1:0] push_value,
  input  logic signed [DATA_W-1:0] range_low,
  input  logic signed [DATA_W-1:0] range_high,
  output logic                     done,
  output logic [STATUS_W-1:0]      status,
  output logic signed [DATA_W-1:0] read_data,
  output logic [CNT_W-1:0]         fill_count
);

  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int ADDR_W = IDX_W + 1;

  state_t                   state, state_next;
  opcode_t                  op, op_next;
  logic signed [DATA_W-1:0] val, val_next;
  logic signed [DATA_W-1:0] lo, lo_next;
  logic signed [DATA_W-1:0] hi, hi_next;
  logic [IDX_W-1:0]         head, head_next;
  logic [IDX_W-1:0]         tail, tail_next;
  logic [CNT_W-1:0]         count, count_next;
  logic                     bank, bank_next;
  logic [CNT_W-1:0]         idx, idx_next;
  logic [CNT_W-1:0]         wptr, wptr_next;
  logic signed [DATA_W-1:0] tmp, tmp_next;

  logic                     finish;
  status_t                  st_res;
  logic signed [DATA_W-1:0] data_res;

  logic [IDX_W-1:0]         alu_base;
  logic [CNT_W-1:0]         alu_off;
  logic [IDX_W-1:0]         alu_addr;
  logic                     alu_in_range;

  logic                     mem_we;
  logic [ADDR_W-1:0]        mem_waddr;
  logic signed [DATA_W-1:0] mem_wdata;
  logic [ADDR_W-1:0]        mem_raddr;
  logic signed [DATA_W-1:0] mem_rdata;

  logic [CNT_W-1:0]         idx_inc;
  logic [CNT_W-1:0]         mirror_off;
  logic [CNT_W-1:0]         kept;

  ringf_mem #(
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ringf_alu #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W),
    .CNT_W    (CNT_W)
  ) u_alu (
    .base       (alu_base),
    .offset     (alu_off),
    .value      (mem_rdata),
    .range_low  (lo),
    .range_high (hi),
    .addr       (alu_addr),
    .in_range   (alu_in_range)
  );

  assign busy       = (state != S_IDLE);
  assign idx_inc    = CNT_W'(idx + 1'b1);
  assign mirror_off = CNT_W'(count - 1'b1 - idx);
  assign kept       = alu_in_range ? wptr : CNT_W'(wptr + 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      tail  <= '0;
      count <= '0;
      bank  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
      bank  <= bank_next;
      done  <= finish;
    end
  end

  always_ff @(posedge clk) begin
    op   <= op_next;
    val  <= val_next;
    lo   <= lo_next;
    hi   <= hi_next;
    idx  <= idx_next;
    wptr <= wptr_next;
    tmp  <= tmp_next;
    if (finish) begin
      status     <= st_res;
      read_data  <= data_res;
      fill_count <= count_next;
    end
  end

  always_comb begin
    state_next = state;
    op_next    = op;
    val_next   = val;
    lo_next    = lo;
    hi_next    = hi;
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    bank_next  = bank;
    idx_next   = idx;
    wptr_next  = wptr;
    tmp_next   = tmp;
    finish     = 1'b0;
    st_res     = ST_OK;
    data_res   = '0;
    alu_base   = head;
    alu_off    = idx;
    mem_we     = 1'b0;
    mem_waddr  = {bank, alu_addr};
    mem_wdata  = mem_rdata;
    mem_raddr  = {bank, head};

    case (state)
      S_IDLE: begin
        // read at head now so pop and peek have data in the next cycle
        if (start) begin
          op_next    = opcode_t'(opcode);
          val_next   = push_value;
          lo_next    = range_low;
          hi_next    = range_high;
          idx_next   = '0;
          wptr_next  = '0;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        alu_off = CNT_W'(1);
        case (op)
          OP_PUSH: begin
            alu_base = tail;
            finish   = 1'b1;
            if (count == CNT_W'(CAPACITY)) begin
              st_res = ST_OVER;
            end else begin
              mem_we     = 1'b1;
              mem_waddr  = {bank, tail};
              mem_wdata  = val;
              tail_next  = alu_addr;
              count_next = CNT_W'(count + 1'b1);
            end
          end
          OP_POP: begin
            finish = 1'b1;
            if (count == '0) begin
              st_res = ST_UNDER;
            end else begin
              data_res   = mem_rdata;
              head_next  = alu_addr;
              count_next = CNT_W'(count - 1'b1);
            end
          end
          OP_PEEK: begin
            finish = 1'b1;
            if (count == '0) begin
              st_res = ST_UNDER;
            end else begin
              data_res = mem_rdata;
            end
          end
          OP_REVERSE: begin
            if (count < CNT_W'(2)) begin
              finish = 1'b1;
            end else begin
              state_next = S_REV_RA;
            end
          end
          OP_REMOVE: begin
            if (count == '0) begin
              finish = 1'b1;
            end else begin
              state_next = S_RM_RD;
            end
          end
          default: begin
            finish = 1'b1;
          end
        endcase
      end
      S_REV_RA: begin
        mem_raddr  = {bank, alu_addr};
        state_next = S_REV_RB;
      end
      S_REV_RB: begin
        // hold the front word, fetch its mirror
        tmp_next   = mem_rdata;
        alu_off    = mirror_off;
        mem_raddr  = {bank, alu_addr};
        state_next = S_REV_WA;
      end
      S_REV_WA: begin
        mem_we     = 1'b1;
        state_next = S_REV_WB;
      end
      S_REV_WB: begin
        alu_off   = mirror_off;
        mem_we    = 1'b1;
        mem_wdata = tmp;
        idx_next  = idx_inc;
        if (idx_inc == (count >> 1)) begin
          finish = 1'b1;
        end else begin
          state_next = S_REV_RA;
        end
      end
      S_RM_RD: begin
        mem_raddr  = {bank, alu_addr};
        state_next = S_RM_CHK;
      end
      S_RM_CHK: begin
        // pack survivors from slot zero of the other half
        mem_waddr = {~bank, wptr[IDX_W-1:0]};
        mem_we    = ~alu_in_range;
        wptr_next = kept;
        idx_next  = idx_inc;
        if (idx_inc == count) begin
          finish     = 1'b1;
          count_next = kept;
          head_next  = '0;
          tail_next  = (kept == CNT_W'(CAPACITY)) ? '0 : kept[IDX_W-1:0];
          bank_next  = ~bank;
        end else begin
          state_next = S_RM_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (finish) begin
      state_next = S_IDLE;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_empty_aligned: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (head == tail))
    else $error("empty queue with head and tail apart");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");

  a_done_from_work: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) != S_IDLE))
    else $error("result without an item in progress");

endmodule

// ----- src/ringf_mem.sv -----
// Entry store: one write port, one registered read port.
module ringf_mem import ringf_pkg::*; #(
  parameter int ADDR_W = 5
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [ADDR_W-1:0]        waddr,
  input  logic signed [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0]        raddr,
  output logic signed [DATA_W-1:0] rdata
);

  localparam int DEPTH = 2 ** ADDR_W;

  logic signed [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/ringf_alu.sv -----
// Shared unit: ring index wrap-add and signed inclusive range compare.
module ringf_alu import ringf_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int IDX_W    = 4,
  parameter int CNT_W    = 5
) (
  input  logic [IDX_W-1:0]         base,
  input  logic [CNT_W-1:0]         offset,
  input  logic signed [DATA_W-1:0] value,
  input  logic signed [DATA_W-1:0] range_low,
  input  logic signed [DATA_W-1:0] range_high,
  output logic [IDX_W-1:0]         addr,
  output logic                     in_range
);

  localparam int SUM_W = CNT_W + 1;

  logic [SUM_W-1:0] sum;

  always_comb begin
    sum = SUM_W'(base) + SUM_W'(offset);
    // base < CAPACITY and offset <= CAPACITY, so one subtract wraps it
    if (sum >= SUM_W'(CAPACITY)) begin
      sum = sum - SUM_W'(CAPACITY);
    end
    addr     = sum[IDX_W-1:0];
    in_range = (range_low <= value) && (value <= range_high);
  end

endmodule
